// File: rtl/npd_pkg.sv
// Shared types, widths and the squared-distance function of the nearest point demapper.
// Depends on nothing; every other file of the block imports it.
package npd_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_W    = 16;
    localparam int PIDX_W     = 6;
    localparam int BPS_W      = 3;
    localparam logic [BPS_W-1:0] BPS_RESET = 3'd2;

    localparam int NB_MAX = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W = COORD_W + 1;
    localparam int D_W    = 2 * COORD_W + 1;
    localparam int Q_W    = 16;
    localparam int FRAC   = 8;

    localparam int S_TDATA_W = ((PIDX_W + 2 * COORD_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 * COORD_W + 2 * PIDX_W + Q_W;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [D_W-1:0] dist_t;
    typedef logic [PIDX_W-1:0] pidx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIST,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    // Search token that walks the row of cells.
    typedef struct packed {
        logic   valid;
        coord_t s_i;
        coord_t s_q;
        dist_t  best_d;
        pidx_t  best_idx;
        coord_t best_i;
        coord_t best_q;
    } tok_t;

    typedef struct packed {
        logic load;
        logic active;
        logic capture;
        logic shift;
    } cell_ctl_t;

    // One slot of the divider pipeline.
    typedef struct packed {
        logic           valid;
        dist_t          rem;
        logic [Q_W-1:0] quo;
        logic           sat;
        pidx_t          idx;
        logic           last;
    } div_t;

    function automatic dist_t sq_dist(input coord_t a_i, input coord_t a_q,
                                      input coord_t b_i, input coord_t b_q);
        logic signed [DIFF_W-1:0]   dx;
        logic signed [DIFF_W-1:0]   dy;
        logic signed [2*DIFF_W-1:0] px;
        logic signed [2*DIFF_W-1:0] py;
        logic [2*DIFF_W-1:0]        sum;
        dx  = {a_i[COORD_W-1], a_i} - {b_i[COORD_W-1], b_i};
        dy  = {a_q[COORD_W-1], a_q} - {b_q[COORD_W-1], b_q};
        px  = dx * dx;
        py  = dy * dy;
        sum = px + py;
        return sum[D_W-1:0];
    endfunction

endpackage

// File: rtl/npd_cell.sv
// One cell of the demapper row: holds one constellation point, refines the passing search token
// and keeps a distance word that shifts toward cell zero. Depends on npd_pkg.
module npd_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  npd_pkg::cell_ctl_t ctl,
    input  npd_pkg::pidx_t     cell_idx,
    input  npd_pkg::coord_t    ld_i,
    input  npd_pkg::coord_t    ld_q,
    input  npd_pkg::coord_t    snap_i,
    input  npd_pkg::coord_t    snap_q,
    input  npd_pkg::tok_t      tok_in,
    output npd_pkg::tok_t      tok_out,
    input  npd_pkg::dist_t     dist_in,
    output npd_pkg::dist_t     dist_out,
    output npd_pkg::coord_t    pt_i,
    output npd_pkg::coord_t    pt_q
);
    import npd_pkg::*;

    coord_t pt_i_reg;
    coord_t pt_q_reg;
    tok_t   tok_reg;
    tok_t   tok_next;
    dist_t  dist_reg;
    dist_t  dist_next;
    coord_t op_i;
    coord_t op_q;
    dist_t  d;

    always_comb begin
        op_i = ctl.capture ? snap_i : tok_in.s_i;
        op_q = ctl.capture ? snap_q : tok_in.s_q;
        d    = sq_dist(op_i, op_q, pt_i_reg, pt_q_reg);

        tok_next       = tok_in;
        tok_next.valid = tok_in.valid && ctl.active;
        // Strict compare keeps the lowest index on a tie.
        if (tok_in.valid && (d < tok_in.best_d)) begin
            tok_next.best_d   = d;
            tok_next.best_idx = cell_idx;
            tok_next.best_i   = pt_i_reg;
            tok_next.best_q   = pt_q_reg;
        end

        dist_next = dist_reg;
        if (ctl.capture) begin
            dist_next = d;
        end else if (ctl.shift) begin
            dist_next = dist_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            pt_i_reg <= ld_i;
            pt_q_reg <= ld_q;
        end
        dist_reg <= dist_next;
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out  = tok_reg;
    assign dist_out = dist_reg;
    assign pt_i     = pt_i_reg;
    assign pt_q     = pt_q_reg;

endmodule

// File: rtl/npd_div_stage.sv
// One restoring-division step: produces one quotient bit per stage, stalls on a shared advance.
// Depends on npd_pkg.
module npd_div_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  npd_pkg::dist_t norm,
    input  npd_pkg::div_t  st_in,
    output npd_pkg::div_t  st_out
);
    import npd_pkg::*;

    div_t           st_reg;
    div_t           st_next;
    logic [D_W:0]   rem_s;
    logic [Q_W-1:0] quo_s;

    always_comb begin
        rem_s = {st_in.rem, st_in.quo[Q_W-1]};
        quo_s = {st_in.quo[Q_W-2:0], 1'b0};
        if (rem_s >= {1'b0, norm}) begin
            rem_s    = rem_s - {1'b0, norm};
            quo_s[0] = 1'b1;
        end
        st_next     = st_in;
        st_next.rem = rem_s[D_W-1:0];
        st_next.quo = quo_s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.valid <= 1'b0;
        end else if (adv) begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

// File: rtl/nearest_point_demapper.sv
// Top level of the nearest point demapper: sequencer, row of point cells, divider pipeline.
// Depends on npd_pkg, npd_cell and npd_div_stage.
//
// Usage. Words enter on the s_ channel. A word with tuser set loads one constellation point
// into the cell named by point_index; loading point 0 or 1 also recomputes the norm, and
// s_tready is held low while it does. A word with tuser clear is a received sample.
// bits_per_symbol is written through cfg_we / cfg_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce. n points are in use,
// n = 2^bits_per_symbol (clamped to 1..6 bits). A sample token walks the first n cells,
// one cell per cycle, keeping the nearest point (lowest index on a tie). All cells then
// measure their distance to the snapped point in the same cycle, and those distances shift
// out of cell 0, one per cycle while m_tready does not stall them, into a 16-stage
// restoring divider. The m_ channel gives n result words with m_tlast on the final one.
// Loads and samples are taken only in idle, and no further word is accepted until the final
// result of the current sample has been taken, after the cell row walk, the distance shift
// and the divider pipeline.
// A stall on m_tready freezes the divider and the shift of the cell row; no word is lost.
// Reset (aresetn low, synchronous) clears the control state, sets four points in use and
// a zero norm; the constellation is not cleared and must be loaded before use.
module nearest_point_demapper (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [npd_pkg::BPS_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: point_index, coord_i, coord_q, zero fill.
    input  logic [npd_pkg::S_TDATA_W-1:0]  s_tdata,
    // Field: kind.
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0: snapped_i, snapped_q, nearest_index, entry_index, norm_distance, fill.
    output logic [npd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);
    import npd_pkg::*;

    localparam int CI_LSB = PIDX_W;
    localparam int CQ_LSB = PIDX_W + COORD_W;
    localparam int M_PAD  = M_TDATA_W - M_FIELDS_W;
    localparam int LIM_W  = D_W + Q_W - FRAC;

    logic [BPS_W-1:0] bps_reg;
    state_t           state_reg;
    state_t           state_next;
    logic             norm_pend_reg;
    dist_t            norm_reg;
    tok_t             tok0_reg;
    coord_t           snap_i_reg;
    coord_t           snap_q_reg;
    pidx_t            snap_idx_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic [BPS_W-1:0] eff_b;
    logic [CNT_W-1:0] n_use;
    tok_t             tok_chain [MAX_POINTS+1];
    tok_t             tap;
    dist_t            dist_chain [MAX_POINTS+1];
    coord_t           pt_i [MAX_POINTS];
    coord_t           pt_q [MAX_POINTS];
    cell_ctl_t        ctl [MAX_POINTS];
    div_t             div_chain [Q_W+1];
    div_t             div_in;
    div_t             div_out;
    logic [LIM_W-1:0] lim;
    logic [Q_W-1:0]   norm_dist;

    logic   adv;
    logic   ready_c;
    logic   s_accept;
    logic   ld_accept;
    logic   smp_accept;
    logic   capture;
    logic   issue;
    logic   in_kind;
    pidx_t  in_idx;
    coord_t in_i;
    coord_t in_q;

    // Input word unpacking.
    assign in_kind = s_tuser[0];
    assign in_idx  = s_tdata[PIDX_W-1:0];
    assign in_i    = s_tdata[CI_LSB +: COORD_W];
    assign in_q    = s_tdata[CQ_LSB +: COORD_W];

    assign s_tready   = ready_c;
    assign s_accept   = s_tvalid && ready_c;
    assign ld_accept  = s_accept && (in_kind == KIND_LOAD);
    assign smp_accept = s_accept && (in_kind == KIND_SAMPLE);

    assign adv = !m_tvalid || m_tready;

    // Points in use, with out-of-range register codes clamped.
    always_comb begin
        eff_b = bps_reg;
        if (bps_reg < BPS_W'(1)) begin
            eff_b = BPS_W'(1);
        end
        if (bps_reg > BPS_W'(NB_MAX)) begin
            eff_b = BPS_W'(NB_MAX);
        end
        n_use = CNT_W'(1) << eff_b;
    end

    // The search ends at the output of the last cell in use.
    always_comb begin
        tap = tok_chain[MAX_POINTS];
        for (int b = 1; b <= NB_MAX; b++) begin
            if (eff_b == BPS_W'(b)) begin
                tap = tok_chain[1 << b];
            end
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        ready_c    = 1'b0;
        capture    = 1'b0;
        issue      = 1'b0;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                ready_c = !norm_pend_reg;
                if (s_tvalid && ready_c && (in_kind == KIND_SAMPLE)) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (tap.valid) begin
                    state_next = ST_DIST;
                end
            end
            ST_DIST: begin
                capture    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                issue = adv;
                if (adv) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cnt_reg == n_use - CNT_W'(1)) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (m_tvalid && m_tready && m_tlast) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bps_reg       <= BPS_RESET;
            norm_pend_reg <= 1'b0;
            norm_reg      <= '0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            norm_pend_reg <= ld_accept && (in_idx <= PIDX_W'(1));
            if (cfg_we) begin
                bps_reg <= cfg_wdata;
            end
            // The cells already hold the new point when the norm is taken.
            if (norm_pend_reg) begin
                norm_reg <= sq_dist(pt_i[0], pt_q[0], pt_i[1], pt_q[1]);
            end
        end
    end

    // Search token entering cell 0, and the snapped point taken from the end of the search.
    always_ff @(posedge aclk) begin
        if (smp_accept) begin
            tok0_reg.s_i      <= in_i;
            tok0_reg.s_q      <= in_q;
            tok0_reg.best_d   <= '1;
            tok0_reg.best_idx <= '0;
            tok0_reg.best_i   <= '0;
            tok0_reg.best_q   <= '0;
        end
        if ((state_reg == ST_SEARCH) && tap.valid) begin
            snap_i_reg   <= tap.best_i;
            snap_q_reg   <= tap.best_q;
            snap_idx_reg <= tap.best_idx;
        end
        if (!aresetn) begin
            tok0_reg.valid <= 1'b0;
        end else begin
            tok0_reg.valid <= smp_accept;
        end
    end

    assign tok_chain[0]           = tok0_reg;
    assign dist_chain[MAX_POINTS] = '0;

    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
        assign ctl[k] = '{
            load:    ld_accept && (in_idx == PIDX_W'(k)),
            active:  (CNT_W'(k) < n_use),
            capture: capture,
            shift:   issue
        };

        npd_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl[k]),
            .cell_idx (PIDX_W'(k)),
            .ld_i     (in_i),
            .ld_q     (in_q),
            .snap_i   (snap_i_reg),
            .snap_q   (snap_q_reg),
            .tok_in   (tok_chain[k]),
            .tok_out  (tok_chain[k+1]),
            .dist_in  (dist_chain[k+1]),
            .dist_out (dist_chain[k]),
            .pt_i     (pt_i[k]),
            .pt_q     (pt_q[k])
        );
    end

    // Divider feed. The quotient saturates when d >= norm * 2^(Q_W-FRAC); a zero norm always
    // lands there, which gives the maximum code for every entry.
    assign lim = {norm_reg, {(Q_W - FRAC){1'b0}}};

    always_comb begin
        div_in.valid = issue;
        div_in.rem   = D_W'(dist_chain[0] >> (Q_W - FRAC));
        div_in.quo   = {dist_chain[0][Q_W-FRAC-1:0], {FRAC{1'b0}}};
        div_in.sat   = (LIM_W'(dist_chain[0]) >= lim);
        div_in.idx   = PIDX_W'(cnt_reg);
        div_in.last  = (cnt_reg == n_use - CNT_W'(1));
    end

    assign div_chain[0] = div_in;

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        npd_div_stage u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .norm    (norm_reg),
            .st_in   (div_chain[j]),
            .st_out  (div_chain[j+1])
        );
    end

    assign div_out   = div_chain[Q_W];
    assign norm_dist = div_out.sat ? '1 : div_out.quo;

    assign m_tvalid = div_out.valid;
    assign m_tlast  = div_out.last;
    assign m_tdata  = {{M_PAD{1'b0}}, norm_dist, div_out.idx, snap_idx_reg,
                       snap_q_reg, snap_i_reg};

`ifndef SYNTHESIS
    a_no_input_while_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while results are pending");

    a_last_ends_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> state_reg == ST_IDLE)
        else $error("sequencer not idle after the final result");

    a_norm_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        norm_pend_reg |-> !s_tready && (state_reg == ST_IDLE))
        else $error("input accepted during norm update");
`endif

endmodule
